### hw/rtl/pwga_pkg.sv
// ----------------------------------------------------------------------------
// pwga_pkg
// Shared types and constants of the pixel-to-world grid accumulator: item
// control, result layout, register indexes and stream widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pwga_pkg;

    // item kind carried on the input tuser bit
    typedef enum logic
    {
        MODE_PIXEL = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    // configuration register indexes
    typedef enum logic [2:0]
    {
        CFG_COS  = 3'd0,
        CFG_SIN  = 3'd1,
        CFG_POSX = 3'd2,
        CFG_POSY = 3'd3,
        CFG_ROWS = 3'd4,
        CFG_COLS = 3'd5
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // stream widths, whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // control travelling with each item down the pipeline
    typedef struct packed
    {
        logic  valid;
        mode_t mode;
        logic  set;
    } item_ctl_t;

    // one result, lowest field in the lowest bits
    typedef struct packed
    {
        logic        updated;
        logic [15:0] cell_count;
        logic [7:0]  cell_y;
        logic [7:0]  cell_x;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/pwga_coord.sv
// ----------------------------------------------------------------------------
// pwga_coord
// Configuration registers and the five-stage pixel-to-cell transform:
// rover frame, rotation, offset, divide by 163840 and clip.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwga_coord #(
    parameter int MAP_SIZE = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [pwga_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pwga_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire pwga_pkg::mode_t                     in_mode,
    input  wire logic [9:0]                          pixel_row,
    input  wire logic [9:0]                          pixel_col,
    input  wire logic                                pixel_set,
    input  wire logic [7:0]                          query_x,
    input  wire logic [7:0]                          query_y,
    output pwga_pkg::item_ctl_t                      m0_ctl,
    output logic [$clog2(MAP_SIZE)-1:0]              m0_cx,
    output logic [$clog2(MAP_SIZE)-1:0]              m0_cy
);

    localparam int CW = $clog2(MAP_SIZE);
    // 163840 = 2^15 * 5; divide by 5 as multiply by 52429 then shift by 18
    localparam logic [29:0] DIV5_MUL = 30'd52429;

    typedef struct packed
    {
        pwga_pkg::item_ctl_t ctl;
        logic [CW-1:0]       qx;
        logic [CW-1:0]       qy;
    } stage_t;

    // configuration registers
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    logic signed [16:0] pos_x_reg;
    logic signed [16:0] pos_y_reg;
    logic [10:0]        rows_reg;
    logic [10:0]        cols_reg;

    // pipeline registers
    stage_t             s0_reg, s1_reg, s2_reg, s3_reg;
    stage_t             s0_next;
    logic signed [11:0] rx_reg, ry_reg;
    logic signed [11:0] rx_next, ry_next;
    logic signed [27:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [29:0] p640x_reg, p640y_reg;
    logic signed [29:0] numx_reg, numy_reg;
    logic               negx_reg, negy_reg;
    logic [29:0]        qmx_reg, qmy_reg;
    logic [CW-1:0]      qx_sat, qy_sat;
    logic [CW-1:0]      wx_next, wy_next;
    pwga_pkg::item_ctl_t m0_ctl_reg;
    logic [CW-1:0]      m0_cx_reg, m0_cy_reg;

    // truncated quotient, negative results clip to zero and large ones to MAP_SIZE-1
    function automatic logic [CW-1:0] clip_cell(input logic neg, input logic [29:0] qm);
        logic [11:0] d;
        d = qm[29:18];
        if (neg)
            clip_cell = '0;
        else if (32'(d) > 32'(MAP_SIZE - 1))
            clip_cell = CW'(MAP_SIZE - 1);
        else
            clip_cell = CW'(d);
    endfunction

    // register writes, unused indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg   <= 16'sd16384;
            sin_reg   <= 16'sd0;
            pos_x_reg <= 17'sd0;
            pos_y_reg <= 17'sd0;
            rows_reg  <= 11'd480;
            cols_reg  <= 11'd640;
        end
        else if (cfg_we)
        begin
            unique case (pwga_pkg::cfg_idx_t'(cfg_index))
                pwga_pkg::CFG_COS:  cos_reg   <= cfg_data[15:0];
                pwga_pkg::CFG_SIN:  sin_reg   <= cfg_data[15:0];
                pwga_pkg::CFG_POSX: pos_x_reg <= cfg_data;
                pwga_pkg::CFG_POSY: pos_y_reg <= cfg_data;
                pwga_pkg::CFG_ROWS: rows_reg  <= cfg_data[10:0];
                pwga_pkg::CFG_COLS: cols_reg  <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // stage 0 inputs: rover frame and saturated query
    always_comb
    begin
        rx_next = $signed({1'b0, rows_reg}) - $signed({2'b00, pixel_row});
        ry_next = $signed({2'b00, pixel_col}) - $signed({2'b00, cols_reg[10:1]});
        qx_sat  = (32'(query_x) > 32'(MAP_SIZE - 1)) ? CW'(MAP_SIZE - 1) : CW'(query_x);
        qy_sat  = (32'(query_y) > 32'(MAP_SIZE - 1)) ? CW'(MAP_SIZE - 1) : CW'(query_y);
        s0_next.ctl.valid = in_valid;
        s0_next.ctl.mode  = in_mode;
        s0_next.ctl.set   = pixel_set;
        s0_next.qx        = qx_sat;
        s0_next.qy        = qy_sat;
    end

    // stage 4 inputs: divided and clipped world cell
    always_comb
    begin
        if (s3_reg.ctl.mode == pwga_pkg::MODE_QUERY)
        begin
            wx_next = s3_reg.qx;
            wy_next = s3_reg.qy;
        end
        else
        begin
            wx_next = clip_cell(negx_reg, qmx_reg);
            wy_next = clip_cell(negy_reg, qmy_reg);
        end
    end

    // item control down the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg     <= '0;
            s1_reg     <= '0;
            s2_reg     <= '0;
            s3_reg     <= '0;
            m0_ctl_reg <= '0;
        end
        else if (en)
        begin
            s0_reg     <= s0_next;
            s1_reg     <= s0_reg;
            s2_reg     <= s1_reg;
            s3_reg     <= s2_reg;
            m0_ctl_reg <= s3_reg.ctl;
        end
    end

    // arithmetic datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            // rotation products
            pxc_reg   <= 28'(rx_reg) * 28'(cos_reg);
            pys_reg   <= 28'(ry_reg) * 28'(sin_reg);
            pxs_reg   <= 28'(rx_reg) * 28'(sin_reg);
            pyc_reg   <= 28'(ry_reg) * 28'(cos_reg);
            // position times 640 as two shifts
            p640x_reg <= (30'(pos_x_reg) <<< 9) + (30'(pos_x_reg) <<< 7);
            p640y_reg <= (30'(pos_y_reg) <<< 9) + (30'(pos_y_reg) <<< 7);
            // numerators
            numx_reg  <= 30'(pxc_reg) - 30'(pys_reg) + p640x_reg;
            numy_reg  <= 30'(pxs_reg) + 30'(pyc_reg) + p640y_reg;
            // drop 2^15 then reciprocal of 5
            negx_reg  <= numx_reg[29];
            negy_reg  <= numy_reg[29];
            qmx_reg   <= 30'(numx_reg[28:15]) * DIV5_MUL;
            qmy_reg   <= 30'(numy_reg[28:15]) * DIV5_MUL;
            m0_cx_reg <= wx_next;
            m0_cy_reg <= wy_next;
        end
    end

    assign m0_ctl = m0_ctl_reg;
    assign m0_cx  = m0_cx_reg;
    assign m0_cy  = m0_cy_reg;

endmodule

`default_nettype wire

### hw/rtl/pwga_map.sv
// ----------------------------------------------------------------------------
// pwga_map
// World map memory with read-modify-write of one cell per cycle while en is
// high, forwarding of the previous write and the clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwga_map #(
    parameter int MAP_SIZE   = 256,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire pwga_pkg::item_ctl_t         m0_ctl,
    input  wire logic [$clog2(MAP_SIZE)-1:0] m0_cx,
    input  wire logic [$clog2(MAP_SIZE)-1:0] m0_cy,
    output logic                             clearing,
    output logic                             res_valid,
    output pwga_pkg::res_t                   res
);

    localparam int CW    = $clog2(MAP_SIZE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    logic [COUNT_BITS-1:0] mem [0:DEPTH-1];

    logic                  clr_active_reg;
    logic [AW-1:0]         clr_addr_reg;

    pwga_pkg::item_ctl_t   m1_ctl_reg;
    logic [CW-1:0]         m1_cx_reg, m1_cy_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic                  fwd_valid_reg;
    logic [AW-1:0]         fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic [AW-1:0]         rd_addr, m1_addr, wr_addr;
    logic [COUNT_BITS-1:0] cur, cur_inc, wr_data;
    logic                  m1_upd, wr_en;

    assign rd_addr = {m0_cy, m0_cx};
    assign m1_addr = {m1_cy_reg, m1_cx_reg};

    // current count, taking the previous update's write if it hit
    always_comb
    begin
        cur     = (fwd_valid_reg && (fwd_addr_reg == m1_addr)) ? fwd_data_reg : rd_data_reg;
        cur_inc = (cur == '1) ? cur : cur + COUNT_BITS'(1);
        m1_upd  = m1_ctl_reg.valid && (m1_ctl_reg.mode == pwga_pkg::MODE_PIXEL)
                  && m1_ctl_reg.set;
    end

    // single write port shared with the clearing pass
    always_comb
    begin
        wr_en   = clr_active_reg || (en && m1_upd);
        wr_addr = clr_active_reg ? clr_addr_reg : m1_addr;
        wr_data = clr_active_reg ? '0 : cur_inc;
    end

    // map memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (en)
            rd_data_reg <= mem[rd_addr];
    end

    // clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == '1)
                clr_active_reg <= 1'b0;
        end
    end

    // update stage control and forwarding state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_ctl_reg    <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_ctl_reg    <= m0_ctl;
            fwd_valid_reg <= m1_upd;
        end
    end

    // update stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_cx_reg    <= m0_cx;
            m1_cy_reg    <= m0_cy;
            fwd_addr_reg <= m1_addr;
            fwd_data_reg <= cur_inc;
        end
    end

    // result of the item in the update stage
    always_comb
    begin
        res = '0;
        if (m1_ctl_reg.mode == pwga_pkg::MODE_QUERY)
        begin
            res.cell_x     = 8'(m1_cx_reg);
            res.cell_y     = 8'(m1_cy_reg);
            res.cell_count = 16'(cur);
        end
        else if (m1_upd)
        begin
            res.cell_x     = 8'(m1_cx_reg);
            res.cell_y     = 8'(m1_cy_reg);
            res.cell_count = 16'(cur_inc);
            res.updated    = 1'b1;
        end
    end

    assign res_valid = en && m1_ctl_reg.valid;
    assign clearing  = clr_active_reg;

endmodule

`default_nettype wire

### hw/rtl/pwga_out_buf.sv
// ----------------------------------------------------------------------------
// pwga_out_buf
// Output register with a skid stage; gives the pipeline its advance enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwga_out_buf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pwga_pkg::res_t push_data,
    input  wire logic           m_ready,
    output logic                m_valid,
    output pwga_pkg::res_t      m_data,
    output logic                en
);

    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    pwga_pkg::res_t out_data_reg, out_data_next;
    pwga_pkg::res_t skid_data_reg, skid_data_next;
    logic           pop;

    assign pop = out_valid_reg && m_ready;
    assign en  = !skid_valid_reg || m_ready;

    // next state of the two entries
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        priority if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next  = push;
                out_data_next   = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
        else
        begin
            out_valid_next  = out_valid_reg;
        end
    end

    // entry valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // entry data
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

### hw/rtl/pixel_to_world_grid_accumulate.sv
// ----------------------------------------------------------------------------
// pixel_to_world_grid_accumulate
// Accumulates set pixels of a bird's-eye image into a world occupancy grid
// and reads single grid cells back.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata: row, col, set, qx, qy; tuser: mode
//  m_axis    out  m_axis_tvalid/tready        tdata: cell_x, cell_y, count, updated
//  cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
//  one item per clock unless the pipeline holds or the map is clearing; the
//  memory read-modify-write stage forwards the previous write
//  after reset a clearing pass zeroes all 2^(2*clog2(MAP_SIZE)) cells (65536 by
//  default); s_axis_tready stays low meanwhile
//  an output register and a skid entry part the sides; the pipeline holds
//  only when both are full and m_axis_tready is low; cfg_ready is always high
//  unchecked by the block, the user must change registers only while the block is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_to_world_grid_accumulate #(
    parameter int MAP_SIZE   = 256,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // pixel_row[9:0], pixel_col[19:10], pixel_set[20], query_x[28:21],
    // query_y[36:29], zero pad
    input  wire logic [pwga_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // mode[0]
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // cell_x[7:0], cell_y[15:8], cell_count[31:16], updated[32], zero pad
    output logic [pwga_pkg::M_TDATA_W-1:0]          m_axis_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pwga_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pwga_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW    = $clog2(MAP_SIZE);
    localparam int M_PAD = pwga_pkg::M_TDATA_W - $bits(pwga_pkg::res_t);

    logic                en;
    logic                clearing;
    logic                in_valid;
    pwga_pkg::item_ctl_t m0_ctl;
    logic [CW-1:0]       m0_cx, m0_cy;
    logic                res_valid;
    pwga_pkg::res_t      res, m_data;

    // request acceptance
    assign s_axis_tready = en && !clearing;
    assign in_valid      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // transform pipeline
    pwga_coord #(
        .MAP_SIZE (MAP_SIZE)
    ) u_coord (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .en        (en),
        .in_valid  (in_valid),
        .in_mode   (pwga_pkg::mode_t'(s_axis_tuser)),
        .pixel_row (s_axis_tdata[9:0]),
        .pixel_col (s_axis_tdata[19:10]),
        .pixel_set (s_axis_tdata[20]),
        .query_x   (s_axis_tdata[28:21]),
        .query_y   (s_axis_tdata[36:29]),
        .m0_ctl    (m0_ctl),
        .m0_cx     (m0_cx),
        .m0_cy     (m0_cy)
    );

    // map read-modify-write
    pwga_map #(
        .MAP_SIZE   (MAP_SIZE),
        .COUNT_BITS (COUNT_BITS)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .m0_ctl    (m0_ctl),
        .m0_cx     (m0_cx),
        .m0_cy     (m0_cy),
        .clearing  (clearing),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register and skid
    pwga_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .m_ready   (m_axis_tready),
        .m_valid   (m_axis_tvalid),
        .m_data    (m_data),
        .en        (en)
    );

    assign m_axis_tdata = {{M_PAD{1'b0}}, m_data};

endmodule

`default_nettype wire

### hw/rtl/pwga_checker.sv
// ----------------------------------------------------------------------------
// pwga_checker
// Port-level checks of the grid accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwga_checker #(
    parameter int COUNT_BITS = 16
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [pwga_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // an incremented cell is never zero
    a_upd_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32] |->
            (COUNT_BITS > 16) || (m_axis_tdata[31:16] != 16'd0))
        else $error("updated cell reads zero");

    // no requests taken once reset has been seen, clearing follows it
    a_rst_ready: assert property (@(posedge clk)
        !rst_n |=> !s_axis_tready)
        else $error("request taken during reset");

    // no result straight after reset
    a_rst_out: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result shown after reset");

endmodule

bind pixel_to_world_grid_accumulate pwga_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_pwga_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
